// ===== rtl/mssh64_pkg.sv =====
// Shared types, constants and the microcode table of the streaming hash unit.
package mssh64_pkg;

   localparam logic [63:0] MIX_M      = 64'hc6a4a7935bd1e995;
   localparam int unsigned MIX_R      = 47;
   localparam logic [63:0] SEED_RESET = 64'h000000001F0D3804;

   localparam int unsigned PC_W = 5;
   localparam logic [PC_W-1:0] PC_MIX  = 5'd0;
   localparam logic [PC_W-1:0] PC_FIN  = 5'd9;
   localparam logic [PC_W-1:0] PC_AVAL = 5'd13;

   localparam logic [1:0] MODE_BYTE  = 2'd0;
   localparam logic [1:0] MODE_WORD  = 2'd1;
   localparam logic [1:0] MODE_DWORD = 2'd2;
   localparam logic [1:0] MODE_END   = 2'd3;

   // Multiplier pass: low x low, high x low, low x high of a 64-bit product.
   typedef enum logic [1:0] {
      MUL_NONE = 2'd0,
      MUL_P0   = 2'd1,
      MUL_P1   = 2'd2,
      MUL_P2   = 2'd3
   } mul_type;

   typedef enum logic {
      K_HOLD    = 1'b0,
      K_PROD_XS = 1'b1
   } kwr_type;

   typedef enum logic [2:0] {
      H_HOLD     = 3'd0,
      H_XOR_PROD = 3'd1,
      H_PROD     = 3'd2,
      H_XOR_TAIL = 3'd3,
      H_XS       = 3'd4,
      H_SEED     = 3'd5
   } hwr_type;

   typedef enum logic [1:0] {
      J_NEXT      = 2'd0,
      J_CNT0      = 2'd1,
      J_END_NOFIN = 2'd2,
      J_END       = 2'd3
   } jmp_type;

   typedef struct packed {
      mul_type         mul;
      logic            src_h;
      kwr_type         kwr;
      hwr_type         hwr;
      logic            emit;
      jmp_type         jmp;
      logic [PC_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic blk_now;
      logic fin_now;
      logic fin;
      logic cnt_zero;
      logic out_stall;
   } status_type;

   localparam ucode_type UC_NOP = '{MUL_NONE, 1'b0, K_HOLD, H_HOLD, 1'b0, J_NEXT, 5'd0};

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type uc;
      uc = UC_NOP;
      case (pc)
         // Block mix: k *= M; k ^= k >> R; k *= M; h ^= k; h *= M.
         5'd0: begin uc.mul = MUL_P0; end
         5'd1: begin uc.mul = MUL_P1; end
         5'd2: begin uc.mul = MUL_P2; uc.kwr = K_PROD_XS; end
         5'd3: begin uc.mul = MUL_P0; end
         5'd4: begin uc.mul = MUL_P1; end
         5'd5: begin uc.mul = MUL_P2; uc.hwr = H_XOR_PROD; end
         5'd6: begin uc.mul = MUL_P0; uc.src_h = 1'b1; end
         5'd7: begin uc.mul = MUL_P1; uc.src_h = 1'b1; end
         5'd8: begin
            uc.mul = MUL_P2; uc.src_h = 1'b1; uc.hwr = H_PROD; uc.jmp = J_END_NOFIN;
         end
         // Finish: fold the tail, then the avalanche.
         5'd9: begin uc.hwr = H_XOR_TAIL; uc.jmp = J_CNT0; uc.target = PC_AVAL; end
         5'd10: begin uc.mul = MUL_P0; uc.src_h = 1'b1; end
         5'd11: begin uc.mul = MUL_P1; uc.src_h = 1'b1; end
         5'd12: begin uc.mul = MUL_P2; uc.src_h = 1'b1; uc.hwr = H_PROD; end
         5'd13: begin uc.hwr = H_XS; end
         5'd14: begin uc.mul = MUL_P0; uc.src_h = 1'b1; end
         5'd15: begin uc.mul = MUL_P1; uc.src_h = 1'b1; end
         5'd16: begin
            uc.mul = MUL_P2; uc.src_h = 1'b1; uc.hwr = H_SEED; uc.emit = 1'b1;
            uc.jmp = J_END;
         end
         default: uc = UC_NOP;
      endcase
      return uc;
   endfunction

endpackage

// ===== rtl/mssh64_sequencer.sv =====
// Step counter and microcode fetch that drive the hash datapath.
module mssh64_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_xfer,
   input  mssh64_pkg::status_type status,
   output logic                   busy,
   output mssh64_pkg::ucode_type  ctrl
);

   logic                        busy_ff, busy_in;
   logic [mssh64_pkg::PC_W-1:0] pc_ff, pc_in;
   mssh64_pkg::ucode_type       uc;
   logic                        stall;

   assign uc    = mssh64_pkg::ucode_rom(pc_ff);
   // Only the emitting step waits, and only while the previous result is untaken.
   assign stall = uc.emit && status.out_stall;
   assign busy  = busy_ff;
   assign ctrl  = (busy_ff && !stall) ? uc : mssh64_pkg::UC_NOP;

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (!busy_ff) begin
         if (in_xfer) begin
            if (status.blk_now) begin
               busy_in = 1'b1;
               pc_in   = mssh64_pkg::PC_MIX;
            end else if (status.fin_now) begin
               busy_in = 1'b1;
               pc_in   = mssh64_pkg::PC_FIN;
            end
         end
      end else if (!stall) begin
         pc_in = pc_ff + 1'b1;
         case (uc.jmp)
            mssh64_pkg::J_NEXT: ;
            mssh64_pkg::J_CNT0: begin
               if (status.cnt_zero) pc_in = uc.target;
            end
            mssh64_pkg::J_END_NOFIN: begin
               if (!status.fin) busy_in = 1'b0;
            end
            mssh64_pkg::J_END: busy_in = 1'b0;
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

endmodule

// ===== rtl/mssh64_datapath.sv =====
// Hash state, byte packing, shared 32x32 multiplier and the result register.
module mssh64_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  mssh64_pkg::ucode_type  ctrl,
   input  logic                   in_xfer,
   input  logic [1:0]             in_mode,
   input  logic [63:0]            in_data,
   input  logic                   in_last,
   input  logic                   cfg_we,
   input  logic [63:0]            cfg_data,
   input  logic                   out_ready,
   output logic                   out_valid,
   output logic [63:0]            out_hash,
   output mssh64_pkg::status_type status
);

   logic [63:0] seed_ff, seed_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] k_ff, k_in;
   logic [63:0] buf_ff, buf_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        fin_ff, fin_in;
   logic [63:0] p_ff, p_in;
   logic        rv_ff, rv_in;
   logic [63:0] rh_ff, rh_in;

   // Packing of the incoming bytes behind the pending ones.
   logic [127:0] wide, wide_sh;
   logic [3:0]   nbytes, total;
   logic [5:0]   shamt;
   logic         has_block;
   logic [63:0]  block, mask, pack_buf;

   always_comb begin
      case (in_mode)
         mssh64_pkg::MODE_BYTE: begin
            wide = {56'd0, buf_ff, in_data[7:0]}; nbytes = 4'd1;
         end
         mssh64_pkg::MODE_WORD: begin
            wide = {32'd0, buf_ff, in_data[31:0]}; nbytes = 4'd4;
         end
         mssh64_pkg::MODE_DWORD: begin
            wide = {buf_ff, in_data}; nbytes = 4'd8;
         end
         default: begin
            wide = {64'd0, buf_ff}; nbytes = 4'd0;
         end
      endcase
      total     = {1'b0, cnt_ff} + nbytes;
      has_block = total[3];
      // Bytes beyond a full block stay pending; the block is the eight above them.
      shamt     = {total[2:0], 3'b000};
      wide_sh   = wide >> shamt;
      block     = wide_sh[63:0];
      mask      = (64'd1 << shamt) - 64'd1;
      pack_buf  = has_block ? (wide[63:0] & mask) : wide[63:0];
   end

   // One 32x32 multiplier; three passes give the low 64 bits of x * M.
   logic [63:0] x;
   logic [31:0] ma, mb;
   logic [63:0] prod;
   logic [31:0] hi_sum;
   logic [63:0] prod_fin, prod_xs;

   assign x        = ctrl.src_h ? h_ff : k_ff;
   assign ma       = (ctrl.mul == mssh64_pkg::MUL_P1) ? x[63:32] : x[31:0];
   assign mb       = (ctrl.mul == mssh64_pkg::MUL_P2) ? mssh64_pkg::MIX_M[63:32]
                                                      : mssh64_pkg::MIX_M[31:0];
   assign prod     = {32'd0, ma} * {32'd0, mb};
   assign hi_sum   = p_ff[63:32] + prod[31:0];
   assign prod_fin = {hi_sum, p_ff[31:0]};
   assign prod_xs  = prod_fin ^ (prod_fin >> mssh64_pkg::MIX_R);

   always_comb begin
      seed_in = seed_ff;
      h_in    = h_ff;
      k_in    = k_ff;
      buf_in  = buf_ff;
      cnt_in  = cnt_ff;
      fin_in  = fin_ff;
      p_in    = p_ff;
      rv_in   = rv_ff && !out_ready;
      rh_in   = rh_ff;

      case (ctrl.mul)
         mssh64_pkg::MUL_P0: p_in = prod;
         mssh64_pkg::MUL_P1: p_in = {hi_sum, p_ff[31:0]};
         mssh64_pkg::MUL_P2: ;
         default: ;
      endcase

      case (ctrl.kwr)
         mssh64_pkg::K_PROD_XS: k_in = prod_xs;
         default: ;
      endcase

      case (ctrl.hwr)
         mssh64_pkg::H_XOR_PROD: h_in = h_ff ^ prod_fin;
         mssh64_pkg::H_PROD:     h_in = prod_fin;
         // Pending bytes sit in the low end and the rest of the buffer is zero.
         mssh64_pkg::H_XOR_TAIL: h_in = h_ff ^ buf_ff;
         mssh64_pkg::H_XS:       h_in = h_ff ^ (h_ff >> mssh64_pkg::MIX_R);
         mssh64_pkg::H_SEED: begin
            h_in   = seed_ff;
            buf_in = '0;
            cnt_in = '0;
         end
         default: ;
      endcase

      if (ctrl.emit) begin
         rv_in = 1'b1;
         rh_in = prod_xs;
      end

      if (in_xfer) begin
         buf_in = pack_buf;
         cnt_in = total[2:0];
         k_in   = block;
         fin_in = (in_mode == mssh64_pkg::MODE_END) || in_last;
      end

      if (cfg_we) begin
         seed_in = cfg_data;
         h_in    = cfg_data;
         buf_in  = '0;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= mssh64_pkg::SEED_RESET;
         h_ff    <= mssh64_pkg::SEED_RESET;
         buf_ff  <= '0;
         cnt_ff  <= '0;
         fin_ff  <= 1'b0;
         rv_ff   <= 1'b0;
      end else begin
         seed_ff <= seed_in;
         h_ff    <= h_in;
         buf_ff  <= buf_in;
         cnt_ff  <= cnt_in;
         fin_ff  <= fin_in;
         rv_ff   <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff  <= k_in;
      p_ff  <= p_in;
      rh_ff <= rh_in;
   end

   assign out_valid        = rv_ff;
   assign out_hash         = rh_ff;
   assign status.blk_now   = has_block;
   assign status.fin_now   = (in_mode == mssh64_pkg::MODE_END) || in_last;
   assign status.fin       = fin_ff;
   assign status.cnt_zero  = (cnt_ff == 3'd0);
   assign status.out_stall = rv_ff && !out_ready;

endmodule

// ===== rtl/murmur_style_streaming_hash64_unit.sv =====
// Top level of the streaming 64-bit multiply/xor-shift hash unit.
//
// Items arrive on the req_ channel (mode, data, last) with valid/ready; each
// transfer absorbs a byte, a 32-bit word or a 64-bit word, or just ends the
// message. The finished hash leaves on the rsp_ channel, one transfer per
// message. csr_wr_en/csr_wr_data write the seed and restart the message.
// An item that completes no 8-byte block and ends nothing runs no program.
// An item that completes a block runs a 9-step mix program.
// Ending a message runs a 5 to 8 step finish program after any block mix.
// Each 64-bit product costs three steps on the one 32x32 multiplier, and
// the microcode visits it up to five times per message end.
// Reset loads the seed 0x1F0D3804 and empties the block buffer.
// The result sits in an output register; the next message is accepted while
// it waits, and only the step that writes a new result holds while
// rsp_ready stays low.
module murmur_style_streaming_hash64_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [63:0] req_data,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_hash,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data
);

   logic                   busy;
   logic                   in_xfer;
   mssh64_pkg::ucode_type  ctrl;
   mssh64_pkg::status_type status;

   assign req_ready = !busy;
   assign in_xfer   = req_valid && !busy;

   mssh64_sequencer u_seq (
      .clock   (clock),
      .reset   (reset),
      .in_xfer (in_xfer),
      .status  (status),
      .busy    (busy),
      .ctrl    (ctrl)
   );

   mssh64_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .in_xfer   (in_xfer),
      .in_mode   (req_mode),
      .in_data   (req_data),
      .in_last   (req_last),
      .cfg_we    (csr_wr_en),
      .cfg_data  (csr_wr_data),
      .out_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_hash  (rsp_hash),
      .status    (status)
   );

endmodule
